// ===== hw/rtl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg : shared types and constants for the quadratic root solver
// Root kind codes, the per-beat control struct and the fixed result widths.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int DISC_W = 19;  // discriminant port width
  localparam int ROOT_W = 17;  // root port width
  localparam int KIND_W = 2;

  // divider lanes
  localparam int LANES   = 3;
  localparam int LANE_R1 = 0;
  localparam int LANE_R2 = 1;
  localparam int LANE_IM = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_EQUAL   = 2'd0,
    KIND_TWO     = 2'd1,
    KIND_COMPLEX = 2'd2,
    KIND_AZERO   = 2'd3
  } kind_t;

  typedef struct packed {
    logic  vld;
    kind_t kind;
  } ctl_t;

endpackage

// ===== hw/rtl/qrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt : pipelined scaled integer square root
// floor(sqrt(mag * 2^(2*FRAC_BITS))), one root bit per register stage.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
  parameter int MAG_W     = 18,
  parameter int SQ_W      = 18,
  parameter int FRAC_BITS = 8,
  parameter int SIDE_W    = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qrs_pkg::ctl_t       in_ctl,
  input  logic [MAG_W-1:0]    in_mag,
  input  logic [SIDE_W-1:0]   in_side,
  output qrs_pkg::ctl_t       out_ctl,
  output logic [SQ_W-1:0]     out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int RW = SQ_W + 3;

  qrs_pkg::ctl_t      ctl_r  [SQ_W];
  logic [RW-1:0]      rem_r  [SQ_W];
  logic [SQ_W-1:0]    root_r [SQ_W];
  logic [MAG_W-1:0]   mag_r  [SQ_W];
  logic [SIDE_W-1:0]  side_r [SQ_W];

  for (genvar k = 0; k < SQ_W; k++) begin : g_stage
    localparam int POS = 2 * (SQ_W - 1 - k);

    qrs_pkg::ctl_t      ctl_i;
    logic [RW-1:0]      rem_i;
    logic [SQ_W-1:0]    root_i;
    logic [MAG_W-1:0]   mag_i;
    logic [SIDE_W-1:0]  side_i;
    logic [1:0]         two;
    logic [RW-1:0]      cur;
    logic [RW-1:0]      trial;
    logic               ge;
    logic [RW-1:0]      rem_nxt;
    logic [SQ_W-1:0]    root_nxt;

    if (k == 0) begin : g_first
      assign ctl_i  = in_ctl;
      assign rem_i  = '0;
      assign root_i = '0;
      assign mag_i  = in_mag;
      assign side_i = in_side;
    end else begin : g_next
      assign ctl_i  = ctl_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign mag_i  = mag_r[k-1];
      assign side_i = side_r[k-1];
    end

    if (POS >= 2 * FRAC_BITS) begin : g_bits
      assign two = 2'(mag_i >> (POS - 2 * FRAC_BITS));
    end else begin : g_zero
      assign two = 2'b00;
    end

    always_comb begin
      cur      = {rem_i[RW-3:0], two};
      trial    = RW'({root_i, 2'b01});
      ge       = (cur >= trial);
      rem_nxt  = ge ? (cur - trial) : cur;
      root_nxt = {root_i[SQ_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= ctl_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      mag_r[k]  <= mag_i;
      side_r[k] <= side_i;
    end
  end

  assign out_ctl  = ctl_r[SQ_W-1];
  assign out_root = root_r[SQ_W-1];
  assign out_side = side_r[SQ_W-1];

endmodule

// ===== hw/rtl/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div : pipelined restoring divider, several numerators over one divisor
// One quotient bit per register stage; unsigned magnitudes.
// ----------------------------------------------------------------------------
module qrs_div #(
  parameter int NUM_W  = 19,
  parameter int DEN_W  = 9,
  parameter int SIDE_W = 1
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  qrs_pkg::ctl_t                          in_ctl,
  input  logic [qrs_pkg::LANES-1:0][NUM_W-1:0]   in_num,
  input  logic [DEN_W-1:0]                       in_den,
  input  logic [SIDE_W-1:0]                      in_side,
  output qrs_pkg::ctl_t                          out_ctl,
  output logic [qrs_pkg::LANES-1:0][NUM_W-1:0]   out_quo,
  output logic [SIDE_W-1:0]                      out_side
);

  typedef logic [qrs_pkg::LANES-1:0][NUM_W-1:0] lane_vec_t;
  typedef logic [qrs_pkg::LANES-1:0][DEN_W-1:0] lane_rem_t;

  qrs_pkg::ctl_t      ctl_r  [NUM_W];
  lane_vec_t          num_r  [NUM_W];
  lane_vec_t          quo_r  [NUM_W];
  lane_rem_t          rem_r  [NUM_W];
  logic [DEN_W-1:0]   den_r  [NUM_W];
  logic [SIDE_W-1:0]  side_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    qrs_pkg::ctl_t      ctl_i;
    lane_vec_t          num_i;
    lane_vec_t          quo_i;
    lane_rem_t          rem_i;
    logic [DEN_W-1:0]   den_i;
    logic [SIDE_W-1:0]  side_i;
    lane_vec_t          num_nxt;
    lane_vec_t          quo_nxt;
    lane_rem_t          rem_nxt;

    if (k == 0) begin : g_first
      assign ctl_i  = in_ctl;
      assign num_i  = in_num;
      assign quo_i  = '0;
      assign rem_i  = '0;
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign ctl_i  = ctl_r[k-1];
      assign num_i  = num_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign den_i  = den_r[k-1];
      assign side_i = side_r[k-1];
    end

    for (genvar l = 0; l < qrs_pkg::LANES; l++) begin : g_lane
      logic [DEN_W:0] t;
      logic           ge;
      always_comb begin
        t  = {rem_i[l], num_i[l][NUM_W-1]};
        ge = (t >= {1'b0, den_i});
        rem_nxt[l] = ge ? DEN_W'(t - {1'b0, den_i}) : DEN_W'(t);
        quo_nxt[l] = {quo_i[l][NUM_W-2:0], ge};
        num_nxt[l] = {num_i[l][NUM_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= ctl_i;
      end
    end

    always_ff @(posedge clk) begin
      num_r[k]  <= num_nxt;
      quo_r[k]  <= quo_nxt;
      rem_r[k]  <= rem_nxt;
      den_r[k]  <= den_i;
      side_r[k] <= side_i;
    end
  end

  assign out_ctl  = ctl_r[NUM_W-1];
  assign out_quo  = quo_r[NUM_W-1];
  assign out_side = side_r[NUM_W-1];

endmodule

// ===== hw/rtl/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver : roots of a*x^2 + b*x + c = 0
// Discriminant, root kind and both roots in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | beat taken when
//  ---------+-----------------------------------------+-------------------------
//  input    | start, busy, in_coef_a/b/c              | start && !busy
//  result   | out_valid, out_discriminant, out_root_  | out_valid (one cycle)
//           | kind, out_first/second_real/imag        |
//
//  - One coefficient beat per clock; busy is never raised.
//  - Stages: one front stage, one stage per root bit in the square root, one
//    numerator stage, one stage per quotient bit in the divider, one output
//    register.
//  - Synchronous active-low reset empties the pipeline (control words and out_valid only).
//  - The receiver cannot stall; every result beat is shown for one cycle.
//
module quadratic_root_solver #(
  parameter int COEF_BITS = 8,
  parameter int FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [COEF_BITS-1:0]                  in_coef_a,
  input  logic [COEF_BITS-1:0]                  in_coef_b,
  input  logic [COEF_BITS-1:0]                  in_coef_c,
  output logic                                  out_valid,
  output logic signed [qrs_pkg::DISC_W-1:0]     out_discriminant,
  output logic [qrs_pkg::KIND_W-1:0]            out_root_kind,
  output logic signed [qrs_pkg::ROOT_W-1:0]     out_first_real,
  output logic signed [qrs_pkg::ROOT_W-1:0]     out_second_real,
  output logic signed [qrs_pkg::ROOT_W-1:0]     out_first_imag,
  output logic signed [qrs_pkg::ROOT_W-1:0]     out_second_imag
);

  // widths
  localparam int DW     = 2 * COEF_BITS + 3;          // signed discriminant
  localparam int MAG_W  = 2 * COEF_BITS + 2;          // |delta|
  localparam int SQ_W   = COEF_BITS + FRAC_BITS + 2;  // root bits
  localparam int NBM_W  = COEF_BITS + FRAC_BITS;      // |b| << FRAC_BITS
  localparam int DEN_W  = COEF_BITS + 1;              // 2a
  localparam int NW     = SQ_W + 2;                   // signed numerator
  localparam int N_W    = NW - 1;                     // numerator magnitude
  localparam int RES_W  = (N_W + 1 > qrs_pkg::ROOT_W) ? N_W + 1 : qrs_pkg::ROOT_W;
  localparam int DRES_W = (DW > qrs_pkg::DISC_W) ? DW : qrs_pkg::DISC_W;
  localparam int SSIDE_W = DW + NBM_W + DEN_W;        // carried through sqrt
  localparam int DSIDE_W = DW + qrs_pkg::LANES;       // carried through divider
  localparam int LAT    = SQ_W + N_W + 3;

  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Front stage: discriminant, kind, |delta|, b<<F, 2a
  // --------------------------------------------------------------------------
  logic signed [DW-1:0]    delta_nxt;
  qrs_pkg::ctl_t           f_ctl_nxt;
  logic [MAG_W-1:0]        f_mag_nxt;

  qrs_pkg::ctl_t           f_ctl_r;
  logic [MAG_W-1:0]        f_mag_r;
  logic [SSIDE_W-1:0]      f_side_r;

  always_comb begin
    delta_nxt = $signed(DW'(in_coef_b * in_coef_b))
              - $signed(DW'(in_coef_a * in_coef_c) << 2);
    f_ctl_nxt.vld = start & ~busy;
    priority if (in_coef_a == '0)   f_ctl_nxt.kind = qrs_pkg::KIND_AZERO;
    else if (delta_nxt == '0)       f_ctl_nxt.kind = qrs_pkg::KIND_EQUAL;
    else if (!delta_nxt[DW-1])      f_ctl_nxt.kind = qrs_pkg::KIND_TWO;
    else                            f_ctl_nxt.kind = qrs_pkg::KIND_COMPLEX;
    f_mag_nxt = delta_nxt[DW-1] ? MAG_W'(-delta_nxt) : MAG_W'(delta_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_ctl_r <= '0;
    end else begin
      f_ctl_r <= f_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_mag_r  <= f_mag_nxt;
    f_side_r <= {delta_nxt, NBM_W'({in_coef_b, {FRAC_BITS{1'b0}}}), DEN_W'({in_coef_a, 1'b0})};
  end

  // --------------------------------------------------------------------------
  // Square root of |delta| * 2^(2F)
  // --------------------------------------------------------------------------
  qrs_pkg::ctl_t           s_ctl;
  logic [SQ_W-1:0]         s_root;
  logic [SSIDE_W-1:0]      s_side;

  qrs_sqrt #(
    .MAG_W     (MAG_W),
    .SQ_W      (SQ_W),
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (SSIDE_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (f_ctl_r),
    .in_mag   (f_mag_r),
    .in_side  (f_side_r),
    .out_ctl  (s_ctl),
    .out_root (s_root),
    .out_side (s_side)
  );

  // --------------------------------------------------------------------------
  // Numerator stage: -b<<F +/- s, split into sign and magnitude per lane
  // --------------------------------------------------------------------------
  logic signed [DW-1:0]    s_delta;
  logic [NBM_W-1:0]        s_nbm;
  logic [DEN_W-1:0]        s_den;
  logic signed [NW-1:0]    nb_s;
  logic signed [NW-1:0]    sr_s;
  logic signed [NW-1:0]    n1;
  logic signed [NW-1:0]    n2;
  logic [qrs_pkg::LANES-1:0][N_W-1:0] n_num_nxt;
  logic [qrs_pkg::LANES-1:0]          n_neg_nxt;

  qrs_pkg::ctl_t                      n_ctl_r;
  logic [qrs_pkg::LANES-1:0][N_W-1:0] n_num_r;
  logic [DEN_W-1:0]                   n_den_r;
  logic [DSIDE_W-1:0]                 n_side_r;

  assign {s_delta, s_nbm, s_den} = s_side;

  always_comb begin
    nb_s = -$signed(NW'(s_nbm));
    sr_s = (s_ctl.kind == qrs_pkg::KIND_TWO) ? $signed(NW'(s_root)) : '0;
    n1   = nb_s + sr_s;
    n2   = nb_s - sr_s;
    n_num_nxt[qrs_pkg::LANE_R1] = n1[NW-1] ? N_W'(-n1) : N_W'(n1);
    n_num_nxt[qrs_pkg::LANE_R2] = n2[NW-1] ? N_W'(-n2) : N_W'(n2);
    n_num_nxt[qrs_pkg::LANE_IM] = (s_ctl.kind == qrs_pkg::KIND_COMPLEX) ? N_W'(s_root) : '0;
    n_neg_nxt[qrs_pkg::LANE_R1] = n1[NW-1];
    n_neg_nxt[qrs_pkg::LANE_R2] = n2[NW-1];
    n_neg_nxt[qrs_pkg::LANE_IM] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_ctl_r <= '0;
    end else begin
      n_ctl_r <= s_ctl;
    end
  end

  always_ff @(posedge clk) begin
    n_num_r  <= n_num_nxt;
    n_den_r  <= s_den;
    n_side_r <= {n_neg_nxt, s_delta};
  end

  // --------------------------------------------------------------------------
  // Division by 2a, three numerators abreast
  // --------------------------------------------------------------------------
  qrs_pkg::ctl_t                      d_ctl;
  logic [qrs_pkg::LANES-1:0][N_W-1:0] d_quo;
  logic [DSIDE_W-1:0]                 d_side;

  qrs_div #(
    .NUM_W  (N_W),
    .DEN_W  (DEN_W),
    .SIDE_W (DSIDE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (n_ctl_r),
    .in_num   (n_num_r),
    .in_den   (n_den_r),
    .in_side  (n_side_r),
    .out_ctl  (d_ctl),
    .out_quo  (d_quo),
    .out_side (d_side)
  );

  // --------------------------------------------------------------------------
  // Output register: restore signs, clear roots for a = 0, trim to port width
  // --------------------------------------------------------------------------
  logic [qrs_pkg::LANES-1:0] d_neg;
  logic signed [DW-1:0]      d_delta;
  logic signed [RES_W-1:0]   q1;
  logic signed [RES_W-1:0]   q2;
  logic signed [RES_W-1:0]   qi;
  logic signed [DRES_W-1:0]  dx;
  logic                      azero;

  logic                                  out_valid_r;
  logic signed [qrs_pkg::DISC_W-1:0]     disc_r;
  logic [qrs_pkg::KIND_W-1:0]            kind_r;
  logic signed [qrs_pkg::ROOT_W-1:0]     r1_r;
  logic signed [qrs_pkg::ROOT_W-1:0]     r2_r;
  logic signed [qrs_pkg::ROOT_W-1:0]     i1_r;
  logic signed [qrs_pkg::ROOT_W-1:0]     i2_r;

  assign {d_neg, d_delta} = d_side;

  always_comb begin
    azero = (d_ctl.kind == qrs_pkg::KIND_AZERO);
    q1 = $signed(RES_W'(d_quo[qrs_pkg::LANE_R1]));
    q2 = $signed(RES_W'(d_quo[qrs_pkg::LANE_R2]));
    qi = $signed(RES_W'(d_quo[qrs_pkg::LANE_IM]));
    if (d_neg[qrs_pkg::LANE_R1]) q1 = -q1;
    if (d_neg[qrs_pkg::LANE_R2]) q2 = -q2;
    if (azero) begin
      q1 = '0;
      q2 = '0;
      qi = '0;
    end
    dx = DRES_W'(d_delta);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    disc_r <= dx[qrs_pkg::DISC_W-1:0];
    kind_r <= d_ctl.kind;
    r1_r   <= q1[qrs_pkg::ROOT_W-1:0];
    r2_r   <= q2[qrs_pkg::ROOT_W-1:0];
    i1_r   <= qrs_pkg::ROOT_W'(-qi);
    i2_r   <= qi[qrs_pkg::ROOT_W-1:0];
  end

  assign out_valid        = out_valid_r;
  assign out_discriminant = disc_r;
  assign out_root_kind    = kind_r;
  assign out_first_real   = r1_r;
  assign out_second_real  = r2_r;
  assign out_first_imag   = i1_r;
  assign out_second_imag  = i2_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result beat without a start beat one latency earlier");

  a_imag_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_kind != qrs_pkg::KIND_COMPLEX
      |-> out_first_imag == '0 && out_second_imag == '0)
    else $error("imaginary parts set on a real result");

  a_azero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_kind == qrs_pkg::KIND_AZERO
      |-> out_first_real == '0 && out_second_real == '0)
    else $error("roots given although a is zero");

  a_conj : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_kind == qrs_pkg::KIND_COMPLEX
      |-> out_first_real == out_second_real && out_first_imag == -out_second_imag)
    else $error("complex roots not a conjugate pair");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : testbench for quadratic_root_solver
// Drives coefficient beats through several idling phases, predicts each result
// with a behavioural solver and checks every result beat field by field.
// ----------------------------------------------------------------------------

// Scoreboard: predicts one result per coefficient beat and checks in order.
class root_scoreboard;
  typedef struct {
    logic signed [qrs_pkg::DISC_W-1:0] disc;
    qrs_pkg::kind_t                    kind;
    logic signed [qrs_pkg::ROOT_W-1:0] r1, r2, i1, i2;
  } roots_t;

  roots_t pending_roots[$];
  int     errors;

  function new();
    errors = 0;
  endfunction

  // floor(sqrt(m * 2^16)), digit by digit
  function longint scaled_sqrt(longint m);
    longint rem, root, trial, two;
    int     pos;
    rem  = 0;
    root = 0;
    for (int p = 17; p >= 0; p--) begin
      pos = 2 * p;
      two = (pos >= 16) ? ((m >> (pos - 16)) & 3) : 0;
      rem = (rem << 2) | two;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function void note_coefs(logic [7:0] ca, logic [7:0] cb, logic [7:0] cc);
    roots_t e;
    longint a, b, c, delta, nb, den, s;
    longint r1, r2, i1, i2;
    a = ca;
    b = cb;
    c = cc;
    delta = b * b - 4 * a * c;
    nb = -(b * 256);
    e.disc = delta[qrs_pkg::DISC_W-1:0];
    r1 = 0;
    r2 = 0;
    i1 = 0;
    i2 = 0;
    if (a == 0) begin
      e.kind = qrs_pkg::KIND_AZERO;
    end else begin
      den = 2 * a;
      s = scaled_sqrt(delta < 0 ? -delta : delta);
      // SV integer division truncates toward zero, as required
      if (delta == 0) begin
        e.kind = qrs_pkg::KIND_EQUAL;
        r1 = nb / den;
        r2 = nb / den;
      end else if (delta > 0) begin
        e.kind = qrs_pkg::KIND_TWO;
        r1 = (nb + s) / den;
        r2 = (nb - s) / den;
      end else begin
        e.kind = qrs_pkg::KIND_COMPLEX;
        r1 = nb / den;
        r2 = nb / den;
        i1 = (-s) / den;
        i2 = s / den;
      end
    end
    e.r1 = r1[qrs_pkg::ROOT_W-1:0];
    e.r2 = r2[qrs_pkg::ROOT_W-1:0];
    e.i1 = i1[qrs_pkg::ROOT_W-1:0];
    e.i2 = i2[qrs_pkg::ROOT_W-1:0];
    pending_roots.push_back(e);
  endfunction

  task report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task check_roots(logic signed [qrs_pkg::DISC_W-1:0] disc, logic [1:0] kind,
                   logic signed [qrs_pkg::ROOT_W-1:0] r1,
                   logic signed [qrs_pkg::ROOT_W-1:0] r2,
                   logic signed [qrs_pkg::ROOT_W-1:0] i1,
                   logic signed [qrs_pkg::ROOT_W-1:0] i2);
    roots_t e;
    if (pending_roots.size() == 0) begin
      report("unexpected result beat", 0, 0);
      return;
    end
    e = pending_roots.pop_front();
    if (disc !== e.disc) report("discriminant", disc, e.disc);
    if (kind !== e.kind) report("root_kind", kind, e.kind);
    if (r1 !== e.r1) report("first_real", r1, e.r1);
    if (r2 !== e.r2) report("second_real", r2, e.r2);
    if (i1 !== e.i1) report("first_imag", i1, e.i1);
    if (i2 !== e.i2) report("second_imag", i2, e.i2);
  endtask
endclass

module tb_top;

  localparam int LATENCY  = 40;
  localparam int WATCHDOG = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [7:0] in_coef_a = '0, in_coef_b = '0, in_coef_c = '0;
  logic out_valid;
  logic signed [qrs_pkg::DISC_W-1:0] out_discriminant;
  logic [qrs_pkg::KIND_W-1:0] out_root_kind;
  logic signed [qrs_pkg::ROOT_W-1:0] out_first_real, out_second_real;
  logic signed [qrs_pkg::ROOT_W-1:0] out_first_imag, out_second_imag;

  root_scoreboard sb = new();
  int  idle_cycles = 0;
  int  idle_pct = 0;   // sender idle chance for the current phase

  always #5 clk = ~clk;

  quadratic_root_solver i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid), .out_discriminant(out_discriminant),
    .out_root_kind(out_root_kind), .out_first_real(out_first_real),
    .out_second_real(out_second_real), .out_first_imag(out_first_imag),
    .out_second_imag(out_second_imag)
  );

  // Monitor: notes accepted coefficient beats, checks result beats, and
  // runs the watchdog on cycles where nothing moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_coefs(in_coef_a, in_coef_b, in_coef_c);
      if (out_valid)
        sb.check_roots(out_discriminant, out_root_kind, out_first_real,
                       out_second_real, out_first_imag, out_second_imag);
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // One coefficient beat; start held across back-to-back beats, random gaps.
  task send_coefs(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task pause_line();
    start <= 1'b0;
    @(negedge clk);
  endtask

  // Well-formed mix: bias towards degenerate, real, equal and complex roots
  task send_random();
    logic [7:0] a, b, c;
    int sel;
    sel = $urandom_range(9);
    a = 8'($urandom);
    b = 8'($urandom);
    c = 8'($urandom);
    case (sel)
      0: a = 8'd0;                       // degenerate
      1: begin                           // equal roots: b = 2a, c = a
        a = 8'($urandom_range(1, 127));
        b = {a[6:0], 1'b0};
        c = a;
      end
      2: c = 8'($urandom_range(0, 3));   // mostly two real
      3: b = 8'($urandom_range(0, 7));   // mostly complex
      default: ;
    endcase
    send_coefs(a, b, c);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes and every root kind
    send_coefs(8'd0, 8'd0, 8'd0);
    send_coefs(8'd0, 8'd255, 8'd255);
    send_coefs(8'd255, 8'd255, 8'd255);
    send_coefs(8'd255, 8'd0, 8'd255);   // most negative discriminant
    send_coefs(8'd1, 8'd255, 8'd0);     // largest root magnitude
    send_coefs(8'd1, 8'd2, 8'd1);       // equal roots
    send_coefs(8'd1, 8'd0, 8'd0);       // equal roots at zero
    send_coefs(8'd1, 8'd3, 8'd2);       // two real
    send_coefs(8'd1, 8'd0, 8'd1);       // complex pair
    send_coefs(8'd3, 8'd1, 8'd1);       // non-exact divisions
    send_coefs(8'd1, 8'd255, 8'd255);
    send_coefs(8'd128, 8'd1, 8'd127);
    send_coefs(8'h55, 8'hAA, 8'h55);
    send_coefs(8'hAA, 8'h55, 8'hAA);

    // pressure: hold off until the pipeline drains
    pause_line();
    while (sb.pending_roots.size() != 0) @(negedge clk);

    // random phases: no idling, then 66% and 36% sender idling, then no idling again
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 66 : (ph == 2) ? 36 : 0;
      for (int n = 0; n < 200; n++) send_random();
      if (ph == 1) begin
        pause_line();
        while (sb.pending_roots.size() != 0) @(negedge clk);
      end
    end
    pause_line();

    while (sb.pending_roots.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (sb.errors == 0 && sb.pending_roots.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
